/* sv/lfu_pkg.sv */
// ----------------------------------------------------------------------------
// LFU cache package
// Shared widths, codes, entry layout and controller types for the LFU cache.
// ----------------------------------------------------------------------------
package lfu_pkg;

	localparam int KEY_W   = 32;
	localparam int DATA_W  = 32;
	localparam int COUNT_W = 32;
	localparam int STAMP_W = 48;
	localparam int CAP_W   = 5;

	localparam int DEF_MAX_ENTRIES = 16;

	localparam logic [CAP_W-1:0]   CAP_RESET  = CAP_W'(16);
	localparam logic [DATA_W-1:0]  MISS_VALUE = '1;
	localparam logic [COUNT_W-1:0] COUNT_INIT = COUNT_W'(1);

	localparam logic OP_GET = 1'b0;
	localparam logic OP_PUT = 1'b1;

	typedef struct packed {
		logic [KEY_W-1:0]   key;
		logic [DATA_W-1:0]  data;
		logic [COUNT_W-1:0] count;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_UPDATE
	} state_t;

	typedef struct packed {
		logic clear;
		logic step;
		logic entry_valid;
	} scan_ctl_t;

	typedef struct packed {
		logic               match;
		logic               free_found;
		logic               victim_found;
		logic [DATA_W-1:0]  match_data;
		logic [COUNT_W-1:0] match_count;
	} scan_res_t;

	// Use counts stick at their maximum.
	function automatic logic [COUNT_W-1:0] count_inc(input logic [COUNT_W-1:0] c);
		logic [COUNT_W-1:0] r;
		r = (c == '1) ? c : c + COUNT_W'(1);
		return r;
	endfunction

endpackage

/* sv/lfu_req_if.sv */
// ----------------------------------------------------------------------------
// LFU cache request channel
// Valid/ready channel carrying one get or put request word.
// ----------------------------------------------------------------------------
interface lfu_req_if;
	logic               valid;
	logic               ready;
	logic               op;
	logic signed [31:0] key;
	logic signed [31:0] value;

	modport source (output valid, output op, output key, output value, input ready);
	modport sink   (input valid, input op, input key, input value, output ready);
endinterface

/* sv/lfu_rsp_if.sv */
// ----------------------------------------------------------------------------
// LFU cache response channel
// Valid/ready channel carrying one get response word.
// ----------------------------------------------------------------------------
interface lfu_rsp_if;
	logic               valid;
	logic               ready;
	logic               hit;
	logic signed [31:0] read_value;

	modport source (output valid, output hit, output read_value, input ready);
	modport sink   (input valid, input hit, input read_value, output ready);
endinterface

/* sv/lfu_entry_ram.sv */
// ----------------------------------------------------------------------------
// LFU entry memory
// One write port and one registered read port holding key, data, count, stamp.
// ----------------------------------------------------------------------------
module lfu_entry_ram #(
	parameter int MAX_ENTRIES = lfu_pkg::DEF_MAX_ENTRIES,
	localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
	input  logic                clk,
	input  logic                we,
	input  logic [AW-1:0]       waddr,
	input  lfu_pkg::entry_t     wdata,
	input  logic [AW-1:0]       raddr,
	output lfu_pkg::entry_t     rdata
);
	lfu_pkg::entry_t mem_q [MAX_ENTRIES];
	lfu_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

/* sv/lfu_scan_unit.sv */
// ----------------------------------------------------------------------------
// LFU scan unit
// Looks at one entry per step: key match, first free slot and eviction victim.
// ----------------------------------------------------------------------------
module lfu_scan_unit #(
	parameter int MAX_ENTRIES = lfu_pkg::DEF_MAX_ENTRIES,
	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  lfu_pkg::scan_ctl_t               ctl,
	input  logic [IDX_W-1:0]                 idx,
	input  logic [lfu_pkg::KEY_W-1:0]        key,
	input  lfu_pkg::entry_t                  ent,
	output lfu_pkg::scan_res_t               res,
	output logic [IDX_W-1:0]                 match_idx,
	output logic [IDX_W-1:0]                 free_idx,
	output logic [IDX_W-1:0]                 victim_idx
);
	logic                               match_q, free_q, vict_q;
	logic [IDX_W-1:0]                   match_idx_q, free_idx_q, vict_idx_q;
	logic [lfu_pkg::DATA_W-1:0]         match_data_q;
	logic [lfu_pkg::COUNT_W-1:0]        match_count_q;
	logic [lfu_pkg::COUNT_W-1:0]        vict_count_q;
	logic [lfu_pkg::STAMP_W-1:0]        vict_stamp_q;
	logic                               is_match, is_free, is_better;

	// Strict less-than keeps the lowest slot on a full tie.
	assign is_match  = ctl.step && ctl.entry_valid && (ent.key == key);
	assign is_free   = ctl.step && !ctl.entry_valid && !free_q;
	assign is_better = ctl.step && ctl.entry_valid &&
		(!vict_q || ({ent.count, ent.stamp} < {vict_count_q, vict_stamp_q}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
			free_q  <= 1'b0;
			vict_q  <= 1'b0;
		end else if (ctl.clear) begin
			match_q <= 1'b0;
			free_q  <= 1'b0;
			vict_q  <= 1'b0;
		end else begin
			if (is_match) begin
				match_q <= 1'b1;
			end
			if (is_free) begin
				free_q <= 1'b1;
			end
			if (is_better) begin
				vict_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_match && !match_q) begin
			match_idx_q   <= idx;
			match_data_q  <= ent.data;
			match_count_q <= ent.count;
		end
		if (is_free) begin
			free_idx_q <= idx;
		end
		if (is_better) begin
			vict_idx_q   <= idx;
			vict_count_q <= ent.count;
			vict_stamp_q <= ent.stamp;
		end
	end

	assign res.match        = match_q;
	assign res.free_found   = free_q;
	assign res.victim_found = vict_q;
	assign res.match_data   = match_data_q;
	assign res.match_count  = match_count_q;
	assign match_idx        = match_idx_q;
	assign free_idx         = free_idx_q;
	assign victim_idx       = vict_idx_q;
endmodule

/* sv/lfu_cache_table_top.sv */
// ----------------------------------------------------------------------------
// LFU cache table
// Key-value cache with least-frequently-used eviction, least recently touched
// entry losing among equal counts.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Words carried
//   -------   ---------  ------------------------------------------
//   req       in         op (get/put), key, value
//   rsp       out        hit, read_value (one word per get only)
//   cfg       in         cfg_we / cfg_wdata: capacity_in_use
//
// Each request word passes through the sequencer states in order: S_IDLE
// accepts it, S_SCAN streams every entry out of the entry memory through the
// shared scan unit, S_DRAIN lets the last registered read be scanned, and
// S_UPDATE writes back. The single read port of the entry memory makes the scan
// go one entry at a time. req.ready is high only while the sequencer is idle.
// The response register lets a new request start while a get response waits;
// write-back only stalls if the next get response finds that register full.
// Reset clears the valid marks, the occupancy count and the stamp counter at
// once; there is no clearing pass.
// ----------------------------------------------------------------------------
module lfu_cache_table_top #(
	parameter int MAX_ENTRIES = lfu_pkg::DEF_MAX_ENTRIES
) (
	input  logic                       clk,
	input  logic                       arst_n,
	lfu_req_if.sink                    req,
	lfu_rsp_if.source                  rsp,
	input  logic                       cfg_we,
	input  logic [lfu_pkg::CAP_W-1:0]  cfg_wdata
);
	localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int OCC_W = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W = (OCC_W > lfu_pkg::CAP_W) ? OCC_W : lfu_pkg::CAP_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_ENTRIES - 1);

	// Sequencer and request latch.
	lfu_pkg::state_t               state_q, state_d;
	logic                          op_q;
	logic [lfu_pkg::KEY_W-1:0]     key_q;
	logic [lfu_pkg::DATA_W-1:0]    value_q;
	logic [IDX_W-1:0]              idx_q;

	// Scan issue stage, aligned with the registered memory read.
	logic                          step_s1;
	logic                          valid_s1;
	logic [IDX_W-1:0]              idx_s1;

	// Architectural state held in flops.
	logic [MAX_ENTRIES-1:0]        valid_q;
	logic [OCC_W-1:0]              occ_q;
	logic [lfu_pkg::STAMP_W-1:0]   stamp_q;
	logic [lfu_pkg::CAP_W-1:0]     cap_q;

	// Response register.
	logic                          rsp_vld_q;
	logic                          hit_q;
	logic [lfu_pkg::DATA_W-1:0]    rdval_q;

	// Sequencer outputs.
	logic                          accept;
	logic                          issue;
	logic                          upd_go;

	// Write-back decision.
	logic                          mem_we;
	logic [IDX_W-1:0]              mem_waddr;
	lfu_pkg::entry_t               mem_wdata;
	lfu_pkg::entry_t               mem_rdata;
	logic                          set_valid;
	logic                          occ_inc;

	// Scan unit hookup.
	lfu_pkg::scan_ctl_t            scan_ctl;
	lfu_pkg::scan_res_t            scan_res;
	logic [IDX_W-1:0]              match_idx, free_idx, victim_idx;

	// Capacity, clamped to the table depth.
	logic [CMP_W-1:0]              cap_eff;
	logic                          full;

	assign cap_eff = (CMP_W'(cap_q) > CMP_W'(MAX_ENTRIES)) ? CMP_W'(MAX_ENTRIES)
	                                                       : CMP_W'(cap_q);
	assign full    = CMP_W'(occ_q) >= cap_eff;

	// ------------------------------------------------------------------------
	// Sequencer: next state.
	// ------------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			lfu_pkg::S_IDLE: begin
				if (req.valid) begin
					state_d = lfu_pkg::S_SCAN;
				end
			end
			lfu_pkg::S_SCAN: begin
				if (idx_q == LAST_IDX) begin
					state_d = lfu_pkg::S_DRAIN;
				end
			end
			lfu_pkg::S_DRAIN: begin
				state_d = lfu_pkg::S_UPDATE;
			end
			lfu_pkg::S_UPDATE: begin
				if (upd_go) begin
					state_d = lfu_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = lfu_pkg::S_IDLE;
			end
		endcase
	end

	// ------------------------------------------------------------------------
	// Sequencer: outputs. A put never loads the response register, so it can
	// write back even while an old get response is still waiting.
	// ------------------------------------------------------------------------
	always_comb begin
		req.ready = 1'b0;
		issue     = 1'b0;
		upd_go    = 1'b0;
		case (state_q)
			lfu_pkg::S_IDLE: begin
				req.ready = 1'b1;
			end
			lfu_pkg::S_SCAN: begin
				issue = 1'b1;
			end
			lfu_pkg::S_UPDATE: begin
				upd_go = (op_q == lfu_pkg::OP_PUT) || !rsp_vld_q || rsp.ready;
			end
			default: begin
				req.ready = 1'b0;
			end
		endcase
	end

	assign accept = req.valid && req.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lfu_pkg::S_IDLE;
			idx_q   <= '0;
			step_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			step_s1 <= issue;
			if (accept) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

	// Request word and the per-entry valid mark that rides with the read.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= req.op;
			key_q   <= req.key;
			value_q <= req.value;
		end
		valid_s1 <= valid_q[idx_q];
		idx_s1   <= idx_q;
	end

	// ------------------------------------------------------------------------
	// Entry memory and the shared scan unit.
	// ------------------------------------------------------------------------
	lfu_entry_ram #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (idx_q),
		.rdata (mem_rdata)
	);

	assign scan_ctl.clear       = accept;
	assign scan_ctl.step        = step_s1;
	assign scan_ctl.entry_valid = valid_s1;

	lfu_scan_unit #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_scan (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl        (scan_ctl),
		.idx        (idx_s1),
		.key        (key_q),
		.ent        (mem_rdata),
		.res        (scan_res),
		.match_idx  (match_idx),
		.free_idx   (free_idx),
		.victim_idx (victim_idx)
	);

	// ------------------------------------------------------------------------
	// Write-back. A hit (get or put) bumps the count and restamps the entry,
	// a put also replaces the data. A put of a new key fills the lowest free
	// slot, or the victim once occupancy has reached the capacity. With the
	// capacity at zero a put leaves everything untouched.
	// ------------------------------------------------------------------------
	always_comb begin
		mem_we          = 1'b0;
		mem_waddr       = match_idx;
		mem_wdata.key   = key_q;
		mem_wdata.data  = scan_res.match_data;
		mem_wdata.count = lfu_pkg::count_inc(scan_res.match_count);
		mem_wdata.stamp = stamp_q;
		set_valid       = 1'b0;
		occ_inc         = 1'b0;
		if (upd_go) begin
			if (op_q == lfu_pkg::OP_GET) begin
				mem_we = scan_res.match;
			end else if (cap_eff != '0) begin
				mem_wdata.data = value_q;
				if (scan_res.match) begin
					mem_we = 1'b1;
				end else if (full) begin
					mem_we          = scan_res.victim_found;
					mem_waddr       = victim_idx;
					mem_wdata.count = lfu_pkg::COUNT_INIT;
					set_valid       = scan_res.victim_found;
				end else begin
					mem_we          = scan_res.free_found;
					mem_waddr       = free_idx;
					mem_wdata.count = lfu_pkg::COUNT_INIT;
					set_valid       = scan_res.free_found;
					occ_inc         = scan_res.free_found;
				end
			end
		end
	end

	// Every write-back takes the next stamp, which wraps at 48 bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
			stamp_q <= '0;
			cap_q   <= lfu_pkg::CAP_RESET;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (mem_we) begin
				stamp_q <= stamp_q + lfu_pkg::STAMP_W'(1);
			end
			if (set_valid) begin
				valid_q[mem_waddr] <= 1'b1;
			end
			if (occ_inc) begin
				occ_q <= occ_q + OCC_W'(1);
			end
		end
	end

	// ------------------------------------------------------------------------
	// Response register: one word per get, -1 on a miss.
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (upd_go && (op_q == lfu_pkg::OP_GET)) begin
			rsp_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (upd_go && (op_q == lfu_pkg::OP_GET)) begin
			hit_q   <= scan_res.match;
			rdval_q <= scan_res.match ? scan_res.match_data : lfu_pkg::MISS_VALUE;
		end
	end

	assign rsp.valid      = rsp_vld_q;
	assign rsp.hit        = hit_q;
	assign rsp.read_value = rdval_q;

	// ------------------------------------------------------------------------
	// Assertions.
	// ------------------------------------------------------------------------
	a_occ_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(occ_q))
		else $error("occupancy count disagrees with valid marks");

	a_rsp_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_vld_q) |-> $past(state_q == lfu_pkg::S_UPDATE))
		else $error("response raised outside write-back");

	a_victim_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_go && (op_q == lfu_pkg::OP_PUT) && (cap_eff != '0) && !scan_res.match && full)
		|-> scan_res.victim_found)
		else $error("full table but scan found no victim");

	a_free_when_room: assert property (@(posedge clk) disable iff (!arst_n)
		(upd_go && (op_q == lfu_pkg::OP_PUT) && !scan_res.match && !full)
		|-> scan_res.free_found)
		else $error("room left but scan found no free slot");
endmodule
